### src/ite_pkg.sv
// Shared types, constants and helper functions for the timestamp-to-epoch block.
// Used by the parser, the request queue, the converter and the top level.
// No dependencies.
package ite_pkg;

    localparam int EPOCH_W     = 39;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [2:0] YEAR_DIGITS  = 3'd4;
    localparam logic [2:0] FIELD_DIGITS = 3'd2;

    localparam logic [12:0] ERA_RECIP = 13'd5243;
    localparam logic [5:0]  C100_RECIP = 6'd41;

    typedef enum logic [3:0] {
        PH_YEAR   = 4'd0,
        PH_MONTH  = 4'd1,
        PH_DAY    = 4'd2,
        PH_HOUR   = 4'd3,
        PH_MINUTE = 4'd4,
        PH_SECOND = 4'd5,
        PH_FRAC   = 4'd6,
        PH_OFS_H  = 4'd7,
        PH_OFS_M  = 4'd8,
        PH_TAIL   = 4'd9,
        PH_ERROR  = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        C_IDLE = 3'd0,
        C_ERA  = 3'd1,
        C_YOE  = 3'd2,
        C_DOE  = 3'd3,
        C_DAYS = 3'd4,
        C_MUL  = 3'd5,
        C_SUM  = 3'd6
    } t_cstate;

    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        ofs_neg;
        logic [6:0]  ofs_h;
        logic [6:0]  ofs_m;
    } t_job;

    // Day of a March-based year on which each month starts.
    function automatic logic [8:0] month_start(input logic [6:0] m);
        logic [8:0] r;
        unique case (m)
            7'd3:    r = 9'd0;
            7'd4:    r = 9'd31;
            7'd5:    r = 9'd61;
            7'd6:    r = 9'd92;
            7'd7:    r = 9'd122;
            7'd8:    r = 9'd153;
            7'd9:    r = 9'd184;
            7'd10:   r = 9'd214;
            7'd11:   r = 9'd245;
            7'd12:   r = 9'd275;
            7'd1:    r = 9'd306;
            7'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] mac7(input logic [6:0] acc, input logic [3:0] d);
        return 7'({acc, 3'b000} + {acc, 1'b0} + {3'b000, d});
    endfunction

    function automatic logic [13:0] mac14(input logic [13:0] acc, input logic [3:0] d);
        return 14'({acc, 3'b000} + {acc, 1'b0} + {10'd0, d});
    endfunction

endpackage

### src/iso8601_timestamp_to_epoch.sv
// ISO 8601 timestamp to UTC epoch seconds: top level.
// Connects ite_parser, ite_queue and ite_convert; depends on ite_pkg.
//
// Input channel: one character per request on i_ch with i_valid; the block
// holds o_stall high only while its two-entry request queue is full. A
// character is taken on any edge with i_valid high and o_stall low, so the
// parser sustains one character per cycle. A zero character ends the string.
// Output channel: one result per string on o_epoch_seconds and o_valid_res,
// qualified by o_valid and taken on an edge where i_stall is low.
// Path: when the converter is free, a request goes from the queue into the
// converter, whose steps are a load step, five arithmetic steps each ending
// in a register, and the output write that raises o_valid. The converter
// pops the next request only after the output write of the last one.
// Stall: while i_stall is high the result holds in the output register; the
// converter waits in its final step and the queue fills, after which o_stall
// rises and the parser holds.
// Reset (i_rst_n low, synchronous): parser back to the year field with all
// fields cleared, queue empty, no result pending.
module iso8601_timestamp_to_epoch (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_ch,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ite_pkg::EPOCH_W-1:0] o_epoch_seconds,
    output logic                              o_valid_res
);
    import ite_pkg::*;

    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    ite_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ch    (i_ch),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    ite_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_empty)
    );

    ite_convert u_convert (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (w_empty),
        .i_job           (w_head_job),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_epoch_seconds (o_epoch_seconds),
        .o_valid_res     (o_valid_res)
    );

endmodule

### src/ite_parser.sv
// Front end: takes a character per cycle unless stalled; builds date, time and offset fields.
// On the terminator it pushes a conversion request into the queue and clears itself.
// Depends on ite_pkg.
module ite_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_ch,
    output logic          o_stall,
    input  logic          i_full,
    output logic          o_push,
    output ite_pkg::t_job o_job
);
    import ite_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_month, n_month;
    logic [6:0]  r_day, n_day;
    logic [6:0]  r_hour, n_hour;
    logic [6:0]  r_minute, n_minute;
    logic [6:0]  r_second, n_second;
    logic        r_neg, n_neg;
    logic [6:0]  r_ofs_h, n_ofs_h;
    logic [6:0]  r_ofs_m, n_ofs_m;

    logic       w_accept;
    logic       w_term;
    logic       w_dg;
    logic [3:0] w_d;
    logic       w_sign;
    logic [2:0] w_maxd;
    logic [7:0] w_sep;
    logic       w_layout_ok;
    logic       w_range_ok;
    logic       w_ofs_ok;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_term   = (i_ch == CH_NUL);
    assign w_dg     = (i_ch >= CH_0) && (i_ch <= CH_9);
    assign w_d      = i_ch[3:0];
    assign w_sign   = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
    assign w_maxd   = (r_phase == PH_YEAR) ? YEAR_DIGITS : FIELD_DIGITS;

    always_comb begin
        unique case (r_phase)
            PH_DAY:                w_sep = CH_T;
            PH_HOUR, PH_MINUTE:    w_sep = CH_COLON;
            default:               w_sep = CH_MINUS;
        endcase
    end

    // next phase and digit count
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (w_accept) begin
            if (w_term) begin
                n_phase = PH_YEAR;
                n_count = 3'd0;
            end else begin
                unique case (r_phase)
                    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE: begin
                        if (w_dg) begin
                            if (r_count < w_maxd) begin
                                n_count = r_count + 3'd1;
                            end else begin
                                n_phase = PH_ERROR;
                            end
                        end else if (i_ch == w_sep && r_count != 3'd0) begin
                            n_phase = t_phase'(r_phase + 4'd1);
                            n_count = 3'd0;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_SECOND: begin
                        priority if (w_dg && r_count < FIELD_DIGITS) begin
                            n_count = r_count + 3'd1;
                        end else if (r_count == 3'd0) begin
                            n_phase = PH_ERROR;
                        end else if (i_ch == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else if (w_sign) begin
                            n_phase = PH_OFS_H;
                            n_count = 3'd0;
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                    PH_FRAC: begin
                        if (!w_dg) begin
                            if (w_sign) begin
                                n_phase = PH_OFS_H;
                                n_count = 3'd0;
                            end else begin
                                n_phase = PH_TAIL;
                            end
                        end
                    end
                    PH_OFS_H: begin
                        priority if (w_dg && r_count < FIELD_DIGITS) begin
                            n_count = r_count + 3'd1;
                        end else if (i_ch == CH_COLON && r_count != 3'd0) begin
                            n_phase = PH_OFS_M;
                            n_count = 3'd0;
                        end else if (w_dg) begin
                            n_phase = PH_OFS_M;
                            n_count = 3'd1;
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                    PH_OFS_M: begin
                        if (w_dg) begin
                            n_count = r_count + 3'd1;
                            if (r_count != 3'd0) begin
                                n_phase = PH_TAIL;
                            end
                        end else begin
                            n_phase = PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                    end
                    default: begin
                        n_phase = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // accumulators
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_neg    = r_neg;
        n_ofs_h  = r_ofs_h;
        n_ofs_m  = r_ofs_m;
        if (w_accept) begin
            if (w_term) begin
                n_year   = '0;
                n_month  = '0;
                n_day    = '0;
                n_hour   = '0;
                n_minute = '0;
                n_second = '0;
                n_neg    = 1'b0;
                n_ofs_h  = '0;
                n_ofs_m  = '0;
            end else begin
                unique case (r_phase)
                    PH_YEAR: begin
                        if (w_dg && r_count < YEAR_DIGITS) n_year = mac14(r_year, w_d);
                    end
                    PH_MONTH: begin
                        if (w_dg && r_count < FIELD_DIGITS) n_month = mac7(r_month, w_d);
                    end
                    PH_DAY: begin
                        if (w_dg && r_count < FIELD_DIGITS) n_day = mac7(r_day, w_d);
                    end
                    PH_HOUR: begin
                        if (w_dg && r_count < FIELD_DIGITS) n_hour = mac7(r_hour, w_d);
                    end
                    PH_MINUTE: begin
                        if (w_dg && r_count < FIELD_DIGITS) n_minute = mac7(r_minute, w_d);
                    end
                    PH_SECOND: begin
                        priority if (w_dg && r_count < FIELD_DIGITS) begin
                            n_second = mac7(r_second, w_d);
                        end else if (r_count != 3'd0 && i_ch != CH_DOT && w_sign) begin
                            n_neg = (i_ch == CH_MINUS);
                        end else begin
                        end
                    end
                    PH_FRAC: begin
                        if (w_sign) n_neg = (i_ch == CH_MINUS);
                    end
                    PH_OFS_H: begin
                        priority if (w_dg && r_count < FIELD_DIGITS) begin
                            n_ofs_h = mac7(r_ofs_h, w_d);
                        end else if (i_ch == CH_COLON && r_count != 3'd0) begin
                        end else if (w_dg) begin
                            n_ofs_m = {3'b000, w_d};
                        end else begin
                            n_ofs_h = '0;
                            n_ofs_m = '0;
                        end
                    end
                    PH_OFS_M: begin
                        if (w_dg) begin
                            n_ofs_m = mac7(r_ofs_m, w_d);
                        end else if (r_count == 3'd0) begin
                            n_ofs_h = '0;
                            n_ofs_m = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // request build on the terminator
    always_comb begin
        w_layout_ok = (r_phase == PH_FRAC) || (r_phase == PH_OFS_H) ||
                      (r_phase == PH_OFS_M) || (r_phase == PH_TAIL) ||
                      (r_phase == PH_SECOND && r_count != 3'd0);
        w_range_ok  = (r_month >= 7'd1) && (r_month <= 7'd12) &&
                      (r_day >= 7'd1) && (r_day <= 7'd31);
        w_ofs_ok    = (r_phase == PH_TAIL) || (r_phase == PH_OFS_M && r_count != 3'd0);
        o_push        = w_accept && w_term;
        o_job.ok      = w_layout_ok && w_range_ok;
        o_job.year    = r_year;
        o_job.month   = r_month;
        o_job.day     = r_day;
        o_job.hour    = r_hour;
        o_job.minute  = r_minute;
        o_job.second  = r_second;
        o_job.ofs_neg = w_ofs_ok && r_neg;
        o_job.ofs_h   = w_ofs_ok ? r_ofs_h : 7'd0;
        o_job.ofs_m   = w_ofs_ok ? r_ofs_m : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_YEAR;
            r_count  <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_neg    <= 1'b0;
            r_ofs_h  <= '0;
            r_ofs_m  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_neg    <= n_neg;
            r_ofs_h  <= n_ofs_h;
            r_ofs_m  <= n_ofs_m;
        end
    end

endmodule

### src/ite_queue.sv
// Short request queue between the parser and the converter.
// Two entries of parsed fields held in flip-flops.
// Depends on ite_pkg.
module ite_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ite_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output ite_pkg::t_job o_job,
    output logic          o_empty
);
    import ite_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("request pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("request popped from an empty queue");

endmodule

### src/ite_convert.sv
// Back end: turns one queued request into UTC epoch seconds.
// Days-from-civil sequencer whose arithmetic steps each end in a register, plus the output register.
// Depends on ite_pkg.
module ite_convert (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  ite_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [ite_pkg::EPOCH_W-1:0] o_epoch_seconds,
    output logic                         o_valid_res
);
    import ite_pkg::*;

    t_cstate r_state, n_state;

    t_job                      r_job;
    logic signed [14:0]        r_y;
    logic [8:0]                r_doy;
    logic signed [5:0]         r_era;
    logic signed [20:0]        r_tod;
    logic [8:0]                r_yoe;
    logic [17:0]               r_doe;
    logic signed [23:0]        r_days;
    logic signed [EPOCH_W-1:0] r_dsec;

    logic                      r_out_valid;
    logic signed [EPOCH_W-1:0] r_out_epoch;
    logic                      r_out_ok;

    logic                      w_load_out;
    logic [26:0]               w_era_prod;
    logic [18:0]               w_hms;
    logic [18:0]               w_ofs;
    logic signed [15:0]        w_yoe16;
    logic [14:0]               w_p41;
    logic [17:0]               w_doe;
    logic signed [23:0]        w_days;
    logic signed [41:0]        w_dsec;
    logic signed [EPOCH_W-1:0] w_sum;

    assign w_load_out = (r_state == C_SUM) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE:  if (!i_empty) n_state = C_ERA;
            C_ERA:   n_state = C_YOE;
            C_YOE:   n_state = C_DOE;
            C_DOE:   n_state = C_DAYS;
            C_DAYS:  n_state = C_MUL;
            C_MUL:   n_state = C_SUM;
            C_SUM:   if (w_load_out) n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        o_pop           = (r_state == C_IDLE) && !i_empty;
        o_valid         = r_out_valid;
        o_epoch_seconds = r_out_epoch;
        o_valid_res     = r_out_ok;
    end

    always_comb begin
        w_era_prod = 27'(r_y[13:0]) * 27'(ERA_RECIP);
        w_hms      = 19'(r_job.hour) * 19'd3600 + 19'(r_job.minute) * 19'd60 +
                     19'(r_job.second);
        w_ofs      = 19'(r_job.ofs_h) * 19'd3600 + 19'(r_job.ofs_m) * 19'd60;
        w_yoe16    = 16'(r_y) - 16'(r_era) * 16'sd400;
        w_p41      = 15'(r_yoe) * 15'(C100_RECIP);
        w_doe      = 18'(r_yoe) * 18'd365 + 18'(r_yoe[8:2]) - 18'(w_p41[13:12]) +
                     18'(r_doy);
        w_days     = 24'(r_era) * 24'sd146097 + $signed({6'b000000, r_doe}) -
                     24'sd719468;
        w_dsec     = r_days * 18'sd86400;
        w_sum      = r_dsec + EPOCH_W'(r_tod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_job;
                    r_y   <= $signed({1'b0, i_job.year}) -
                             ((i_job.month <= 7'd2) ? 15'sd1 : 15'sd0);
                    r_doy <= month_start(i_job.month) + 9'(i_job.day) - 9'd1;
                end
            end
            C_ERA: begin
                r_era <= r_y[14] ? -6'sd1 : $signed({1'b0, w_era_prod[25:21]});
                r_tod <= r_job.ofs_neg ? $signed(21'(w_hms) + 21'(w_ofs))
                                       : $signed(21'(w_hms) - 21'(w_ofs));
            end
            C_YOE:  r_yoe  <= w_yoe16[8:0];
            C_DOE:  r_doe  <= w_doe;
            C_DAYS: r_days <= w_days;
            C_MUL:  r_dsec <= w_dsec[EPOCH_W-1:0];
            C_SUM: begin
                if (w_load_out) begin
                    r_out_epoch <= r_job.ok ? w_sum : '0;
                    r_out_ok    <= r_job.ok;
                end
            end
            default: begin
            end
        endcase
    end

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_epoch == '0)
        else $error("rejected timestamp carries a non-zero epoch");

    a_result_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == C_SUM)
        else $error("result raised outside the final step");

endmodule

### test/testbench.sv
// Testbench for iso8601_timestamp_to_epoch: streams timestamp strings one character
// per request and checks each epoch result against a local parser and date conversion.
// Depends on ite_pkg and the block's RTL.
module testbench;
    import ite_pkg::*;

    localparam logic [7:0] CH_Z = 8'h5A;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               ok;
    } t_epoch_res;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_ALT,
        FLOW_RANDOM,
        FLOW_BURST
    } t_flow;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic [7:0]                i_ch = 8'h00;
    logic                      i_stall = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [EPOCH_W-1:0] o_epoch_seconds;
    logic                      o_valid_res;

    logic [7:0]  char_q [$];
    logic [7:0]  str_buf [$];
    t_epoch_res  epochs_due [$];
    int          mismatches = 0;
    logic        ch_taken = 1'b0;
    int          burst_left = 8;
    int          gap_left = 0;
    int          stall_tick = 0;
    t_flow       flow = FLOW_FREE;

    t_phase      ph;
    logic [2:0]  ndig;
    logic [13:0] yr_acc;
    logic [6:0]  dt_acc [1:5];
    logic        oneg;
    logic [6:0]  ofs_h;
    logic [6:0]  ofs_m;

    iso8601_timestamp_to_epoch u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_ch            (i_ch),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_epoch_seconds (o_epoch_seconds),
        .o_valid_res     (o_valid_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [6:0] times_ten(input logic [6:0] acc, input logic [3:0] d);
        return 7'(acc * 10 + d);
    endfunction

    function automatic longint civil_day_count(input longint y, input longint m,
                                               input longint d);
        longint era;
        longint yoe;
        longint doy;
        longint doe;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    task automatic clear_parse();
        ph     = PH_YEAR;
        ndig   = '0;
        yr_acc = '0;
        foreach (dt_acc[i]) dt_acc[i] = '0;
        oneg   = 1'b0;
        ofs_h  = '0;
        ofs_m  = '0;
    endtask

    task automatic close_field(input logic [7:0] c, input logic [7:0] want);
        if (c == want && ndig != 0) begin
            ph   = t_phase'(ph + 1);
            ndig = '0;
        end else begin
            ph = PH_ERROR;
        end
    endtask

    task automatic leave_seconds(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) begin
            oneg = (c == CH_MINUS);
            ph   = PH_OFS_H;
            ndig = '0;
        end else begin
            ph = PH_TAIL;
        end
    endtask

    task automatic drop_offset();
        ofs_h = '0;
        ofs_m = '0;
        ph    = PH_TAIL;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic       dg;
        logic [3:0] d;
        logic       ok;
        longint     off;
        longint     secs;
        dg = (c >= CH_0) && (c <= CH_9);
        d  = c[3:0];
        if (c == CH_NUL) begin
            ok = (ph >= PH_FRAC && ph <= PH_TAIL) || (ph == PH_SECOND && ndig != 0);
            if (dt_acc[PH_MONTH] < 1 || dt_acc[PH_MONTH] > 12 ||
                dt_acc[PH_DAY] < 1 || dt_acc[PH_DAY] > 31) ok = 1'b0;
            secs = 0;
            if (ok) begin
                off = 0;
                if (ph == PH_TAIL || (ph == PH_OFS_M && ndig != 0)) begin
                    off = longint'(ofs_h) * 3600 + longint'(ofs_m) * 60;
                    if (oneg) off = -off;
                end
                secs = civil_day_count(longint'(yr_acc), longint'(dt_acc[PH_MONTH]),
                                       longint'(dt_acc[PH_DAY])) * 86400
                       + longint'(dt_acc[PH_HOUR]) * 3600
                       + longint'(dt_acc[PH_MINUTE]) * 60
                       + longint'(dt_acc[PH_SECOND]) - off;
            end
            epochs_due.push_back({secs[EPOCH_W-1:0], ok});
            clear_parse();
        end else begin
            case (ph)
                PH_YEAR: begin
                    if (dg) begin
                        if (ndig < YEAR_DIGITS) begin
                            yr_acc = 14'(yr_acc * 10 + d);
                            ndig++;
                        end else begin
                            ph = PH_ERROR;
                        end
                    end else begin
                        close_field(c, CH_MINUS);
                    end
                end
                PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE: begin
                    if (dg) begin
                        if (ndig < FIELD_DIGITS) begin
                            dt_acc[ph] = times_ten(dt_acc[ph], d);
                            ndig++;
                        end else begin
                            ph = PH_ERROR;
                        end
                    end else begin
                        close_field(c, ph == PH_MONTH ? CH_MINUS :
                                       ph == PH_DAY   ? CH_T : CH_COLON);
                    end
                end
                PH_SECOND: begin
                    if (dg && ndig < FIELD_DIGITS) begin
                        dt_acc[PH_SECOND] = times_ten(dt_acc[PH_SECOND], d);
                        ndig++;
                    end else if (ndig == 0) begin
                        ph = PH_ERROR;
                    end else if (c == CH_DOT) begin
                        ph = PH_FRAC;
                    end else begin
                        leave_seconds(c);
                    end
                end
                PH_FRAC: begin
                    if (!dg) leave_seconds(c);
                end
                PH_OFS_H: begin
                    if (dg && ndig < FIELD_DIGITS) begin
                        ofs_h = times_ten(ofs_h, d);
                        ndig++;
                    end else if (c == CH_COLON && ndig != 0) begin
                        ph   = PH_OFS_M;
                        ndig = '0;
                    end else if (dg) begin
                        ofs_m = {3'b000, d};
                        ph    = PH_OFS_M;
                        ndig  = 3'd1;
                    end else begin
                        drop_offset();
                    end
                end
                PH_OFS_M: begin
                    if (dg) begin
                        ofs_m = times_ten(ofs_m, d);
                        ndig++;
                        if (ndig >= FIELD_DIGITS) ph = PH_TAIL;
                    end else if (ndig != 0) begin
                        ph = PH_TAIL;
                    end else begin
                        drop_offset();
                    end
                end
                PH_TAIL: begin
                end
                default: begin
                    ph = PH_ERROR;
                end
            endcase
        end
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
    endtask

    task automatic queue_text(input string s);
        push_text(s);
        char_q.push_back(CH_NUL);
    endtask

    task automatic push_digits(input int val, input int nd);
        int scale;
        scale = 1;
        repeat (nd - 1) scale *= 10;
        repeat (nd) begin
            str_buf.push_back(CH_0 + 8'((val / scale) % 10));
            scale /= 10;
        end
    endtask

    task automatic push_field(input int lo, input int hi);
        int val;
        val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
        push_digits(val, (val < 10 && $urandom_range(0, 1) == 1) ? 1 : 2);
    endtask

    task automatic push_offset();
        str_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        case ($urandom_range(0, 2))
            0: begin
                push_field(0, 14);
                str_buf.push_back(CH_COLON);
                push_field(0, 59);
            end
            1: begin
                push_digits($urandom_range(0, 14), 2);
                push_digits($urandom_range(0, 59), $urandom_range(1, 2));
            end
            default: begin
                push_digits($urandom_range(0, 99), $urandom_range(1, 2));
            end
        endcase
        if ($urandom_range(0, 3) == 0) void'(str_buf.pop_back());
    endtask

    task automatic queue_random_timestamp();
        int keep;
        str_buf.delete();
        push_digits($urandom_range(0, 9999), $urandom_range(1, 4));
        str_buf.push_back(CH_MINUS);
        push_field(1, 12);
        str_buf.push_back(CH_MINUS);
        push_field(1, 31);
        str_buf.push_back(CH_T);
        push_field(0, 23);
        str_buf.push_back(CH_COLON);
        push_field(0, 59);
        str_buf.push_back(CH_COLON);
        push_field(0, 60);
        case ($urandom_range(0, 5))
            0: begin
            end
            1: begin
                str_buf.push_back(CH_Z);
            end
            2: begin
                str_buf.push_back(CH_DOT);
                push_digits($urandom_range(0, 999999), $urandom_range(0, 6));
                if ($urandom_range(0, 1) == 1) push_offset();
            end
            default: begin
                push_offset();
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) str_buf.push_back(8'($urandom_range(1, 255)));
        end
        case ($urandom_range(0, 9))
            0: begin
                str_buf[$urandom_range(0, str_buf.size() - 1)] = 8'($urandom_range(1, 255));
            end
            1: begin
                keep = $urandom_range(0, str_buf.size() - 1);
                while (str_buf.size() > keep) void'(str_buf.pop_back());
            end
            2: begin
                str_buf.delete();
                repeat ($urandom_range(0, 30)) str_buf.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
            end
        endcase
        foreach (str_buf[i]) char_q.push_back(str_buf[i]);
        char_q.push_back(CH_NUL);
    endtask

    // sender: bursts of requests separated by random gaps; hold payload while stalled
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || ch_taken)) begin
            if (gap_left != 0 || char_q.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                i_ch    <= char_q.pop_front();
                i_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                            : $urandom_range(1, 12);
                    gap_left   = $urandom_range(1, 6);
                end
            end
        end
    end

    always @(negedge i_clk) begin : receiver_flow
        logic hold;
        stall_tick++;
        if (stall_tick % 97 == 0) flow = t_flow'($urandom_range(0, 3));
        case (flow)
            FLOW_FREE:   hold = 1'b0;
            FLOW_ALT:    hold = stall_tick[0];
            FLOW_RANDOM: hold = ($urandom_range(0, 2) == 0);
            default:     hold = (stall_tick % 16) < 9;
        endcase
        i_stall <= hold;
    end

    always @(posedge i_clk) begin : result_check
        t_epoch_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (epochs_due.size() == 0) begin
                flag_mismatch("result with none outstanding");
            end else begin
                want = epochs_due.pop_front();
                if (o_epoch_seconds !== want.epoch)
                    flag_mismatch($sformatf("epoch_seconds %0d, want %0d",
                                            o_epoch_seconds, $signed(want.epoch)));
                if (o_valid_res !== want.ok)
                    flag_mismatch($sformatf("valid_res %b, want %b", o_valid_res, want.ok));
            end
        end
        ch_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) parse_char(i_ch);
    end

    initial begin
        int strings;
        clear_parse();

        queue_text("1970-01-01T00:00:00Z");
        queue_text("");
        queue_text("0-3-1T0:0:0");
        queue_text("0000-01-01T00:00:00+14:00");
        queue_text("9999-12-31T99:99:99.123456789-14:59");
        queue_text("1969-12-31T23:59:59");
        queue_text("2024-02-29T12:34:56+05:30");
        queue_text("2024-02-29T12:34:56-0800");
        queue_text("2024-02-29T12:34:56+123");
        queue_text("2024-02-29T12:34:56+5");
        queue_text("2024-02-29T12:34:56+05:");
        queue_text("2024-02-29T12:34:56-");
        queue_text("2024-02-29T12:34:567");
        queue_text("2024-13-01T00:00:00");
        queue_text("2024-00-15T00:00:00");
        queue_text("2024-06-00T00:00:00");
        queue_text("2024-06-32T00:00:00");
        queue_text("2024-06-15T10:20");
        queue_text("2024-06-15T10:20:");
        queue_text("2024/06/15T10:20:30");
        queue_text("20245-06-15T10:20:30");
        queue_text("2024-006-15T10:20:30");
        queue_text("-2024-06-15T10:20:30");
        queue_text("2024-06-15T10:20:30.");
        queue_text("2024-06-15T10:20:30.5+01:00:99xyz");
        queue_text("2024-06-15T10:20:30+05X");
        queue_text("2024-06-15T10:20:30+05:X");
        push_text("2024-06-15T10:20:30Z");
        char_q.push_back(8'hFF);
        char_q.push_back(8'h80);
        char_q.push_back(8'h7F);
        char_q.push_back(CH_NUL);
        char_q.push_back(8'hFF);
        queue_text("024-06-15T10:20:30");

        strings = 0;
        while (char_q.size() < 1000 || strings < 15) begin
            queue_random_timestamp();
            strings++;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (char_q.size() != 0 || i_valid || epochs_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
